// File: rtl/sga_pkg.sv
`timescale 1ns / 1ps

package sga_pkg;

  // Fixed field widths of the stream payloads
  localparam int unsigned FIELD_W    = 64;
  localparam int unsigned S_TDATA_W  = 2 * FIELD_W;
  localparam int unsigned M_TDATA_W  = 2 * FIELD_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Row queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AGG_OP       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIGNED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_SIGNED = 2'd2;

  typedef enum logic [1:0] {
    AGG_SUM   = 2'd0,
    AGG_COUNT = 2'd1,
    AGG_MIN   = 2'd2,
    AGG_MAX   = 2'd3
  } agg_op_e;

  typedef enum logic {
    PH_ROW   = 1'b0,
    PH_FINAL = 1'b1
  } back_phase_e;

  // Classification of one row, made by the front
  typedef struct packed {
    logic open_grp;    // row starts a new group
    logic close_prev;  // row closes the group that was open
    logic present;     // value takes part in the aggregate
    logic final_row;   // last row of the table
  } row_flags_t;

  localparam int unsigned FLAGS_W = $bits(row_flags_t);

endpackage

// File: rtl/sga_queue.sv
`timescale 1ns / 1ps

module sga_queue #(
  parameter int unsigned WIDTH = 132
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  logic [WIDTH-1:0]              mem_q [sga_pkg::QDEPTH];
  logic [sga_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [sga_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [sga_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  logic                          push, pop;

  assign in_ready_o  = (cnt_q != sga_pkg::QCNT_W'(sga_pkg::QDEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_ready_i && out_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

// File: rtl/sga_front.sv
`timescale 1ns / 1ps

module sga_front #(
  parameter int unsigned KEY_WIDTH   = 64,
  parameter int unsigned VALUE_WIDTH = 64,
  localparam int unsigned ENTRY_W    = KEY_WIDTH + sga_pkg::FIELD_W + sga_pkg::FLAGS_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        key_signed_i,
  input  logic                        value_signed_i,
  input  logic                        row_valid_i,
  output logic                        row_ready_o,
  input  logic [sga_pkg::FIELD_W-1:0] row_key_i,
  input  logic [sga_pkg::FIELD_W-1:0] row_value_i,
  input  logic                        value_present_i,
  input  logic                        final_row_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output logic [ENTRY_W-1:0]          push_data_o
);

  logic                        group_open_q, group_open_d;
  logic [KEY_WIDTH-1:0]        cur_key_q, cur_key_d;
  logic [KEY_WIDTH-1:0]        key;
  logic [sga_pkg::FIELD_W-1:0] value_ext;
  logic                        key_gt;
  logic                        accept;
  sga_pkg::row_flags_t         flags;

  assign key          = row_key_i[KEY_WIDTH-1:0];
  assign row_ready_o  = push_ready_i;
  assign push_valid_o = row_valid_i;
  assign accept       = row_valid_i && push_ready_i;

  // strictly greater than the group's first key
  assign key_gt = key_signed_i ? ($signed(key) > $signed(cur_key_q)) : (key > cur_key_q);

  always_comb begin
    for (int i = 0; i < sga_pkg::FIELD_W; i++) begin
      if (i < VALUE_WIDTH) begin
        value_ext[i] = row_value_i[i];
      end else begin
        value_ext[i] = value_signed_i & row_value_i[VALUE_WIDTH-1];
      end
    end
  end

  always_comb begin
    flags.open_grp   = !group_open_q || key_gt;
    flags.close_prev = group_open_q && key_gt;
    flags.present    = value_present_i;
    flags.final_row  = final_row_i;
    group_open_d     = group_open_q;
    cur_key_d        = cur_key_q;
    if (accept) begin
      if (final_row_i) begin
        group_open_d = 1'b0;
        cur_key_d    = '0;
      end else if (flags.open_grp) begin
        group_open_d = 1'b1;
        cur_key_d    = key;
      end
    end
  end

  assign push_data_o = {flags, value_ext, key};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_open_q <= 1'b0;
      cur_key_q    <= '0;
    end else begin
      group_open_q <= group_open_d;
      cur_key_q    <= cur_key_d;
    end
  end

endmodule

// File: rtl/sga_back.sv
`timescale 1ns / 1ps

module sga_back #(
  parameter int unsigned KEY_WIDTH = 64,
  localparam int unsigned ENTRY_W  = KEY_WIDTH + sga_pkg::FIELD_W + sga_pkg::FLAGS_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sga_pkg::agg_op_e            agg_op_i,
  input  logic                        value_signed_i,
  input  logic                        row_valid_i,
  output logic                        row_pop_o,
  input  logic [ENTRY_W-1:0]          row_data_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [KEY_WIDTH-1:0]        res_key_o,
  output logic [sga_pkg::FIELD_W-1:0] res_value_o,
  output logic                        res_present_o,
  output logic                        res_last_o
);

  localparam int unsigned VW = sga_pkg::FIELD_W;

  sga_pkg::back_phase_e  phase_q, phase_d;
  logic [KEY_WIDTH-1:0]  key_q, key_d;
  logic [VW-1:0]         acc_q, acc_d;
  logic                  pres_q, pres_d;

  logic                  ovalid_q, ovalid_d;
  logic [KEY_WIDTH-1:0]  okey_q, okey_d;
  logic [VW-1:0]         oval_q, oval_d;
  logic                  opres_q, opres_d;
  logic                  olast_q, olast_d;

  logic [KEY_WIDTH-1:0]  e_key;
  logic [VW-1:0]         e_val;
  sga_pkg::row_flags_t   e_flags;
  logic [KEY_WIDTH-1:0]  base_key;
  logic [VW-1:0]         base_acc, app_acc;
  logic                  base_pres, app_pres;
  logic                  can_load, out_load, lt_new, lt_old;

  assign e_key    = row_data_i[KEY_WIDTH-1:0];
  assign e_val    = row_data_i[KEY_WIDTH +: VW];
  assign e_flags  = sga_pkg::row_flags_t'(row_data_i[KEY_WIDTH+VW +: sga_pkg::FLAGS_W]);
  assign can_load = !ovalid_q || res_ready_i;

  assign base_key  = e_flags.open_grp ? e_key : key_q;
  assign base_acc  = e_flags.open_grp ? '0 : acc_q;
  assign base_pres = e_flags.open_grp ? 1'b0 : pres_q;

  assign lt_new = value_signed_i ? ($signed(e_val) < $signed(base_acc)) : (e_val < base_acc);
  assign lt_old = value_signed_i ? ($signed(base_acc) < $signed(e_val)) : (base_acc < e_val);

  // fold this row's value into the group
  always_comb begin
    app_acc  = base_acc;
    app_pres = base_pres;
    if (e_flags.present) begin
      app_pres = 1'b1;
      case (agg_op_i)
        sga_pkg::AGG_COUNT: app_acc = base_acc + VW'(1);
        sga_pkg::AGG_SUM:   app_acc = base_pres ? base_acc + e_val : e_val;
        sga_pkg::AGG_MIN:   if (!base_pres || lt_new) app_acc = e_val;
        sga_pkg::AGG_MAX:   if (!base_pres || lt_old) app_acc = e_val;
        default:            app_acc = base_acc;
      endcase
    end
  end

  always_comb begin
    phase_d   = phase_q;
    key_d     = key_q;
    acc_d     = acc_q;
    pres_d    = pres_q;
    row_pop_o = 1'b0;
    out_load  = 1'b0;
    okey_d    = okey_q;
    oval_d    = oval_q;
    opres_d   = opres_q;
    olast_d   = olast_q;
    case (phase_q)
      sga_pkg::PH_ROW: begin
        if (row_valid_i) begin
          if (e_flags.close_prev) begin
            if (can_load) begin
              out_load = 1'b1;
              okey_d   = key_q;
              oval_d   = pres_q ? acc_q : '0;
              opres_d  = pres_q;
              olast_d  = 1'b0;
              key_d    = base_key;
              acc_d    = app_acc;
              pres_d   = app_pres;
              if (e_flags.final_row) begin
                phase_d = sga_pkg::PH_FINAL;  // one-row group still to flush
              end else begin
                row_pop_o = 1'b1;
              end
            end
          end else if (e_flags.final_row) begin
            if (can_load) begin
              out_load  = 1'b1;
              okey_d    = base_key;
              oval_d    = app_pres ? app_acc : '0;
              opres_d   = app_pres;
              olast_d   = 1'b1;
              key_d     = '0;
              acc_d     = '0;
              pres_d    = 1'b0;
              row_pop_o = 1'b1;
            end
          end else begin
            key_d     = base_key;
            acc_d     = app_acc;
            pres_d    = app_pres;
            row_pop_o = 1'b1;
          end
        end
      end
      sga_pkg::PH_FINAL: begin
        if (can_load) begin
          out_load  = 1'b1;
          okey_d    = key_q;
          oval_d    = pres_q ? acc_q : '0;
          opres_d   = pres_q;
          olast_d   = 1'b1;
          key_d     = '0;
          acc_d     = '0;
          pres_d    = 1'b0;
          row_pop_o = 1'b1;
          phase_d   = sga_pkg::PH_ROW;
        end
      end
      default: phase_d = sga_pkg::PH_ROW;
    endcase
    if (out_load) begin
      ovalid_d = 1'b1;
    end else if (res_ready_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= sga_pkg::PH_ROW;
      key_q    <= '0;
      acc_q    <= '0;
      pres_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      key_q    <= key_d;
      acc_q    <= acc_d;
      pres_q   <= pres_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okey_q  <= okey_d;
    oval_q  <= oval_d;
    opres_q <= opres_d;
    olast_q <= olast_d;
  end

  assign res_valid_o   = ovalid_q;
  assign res_key_o     = okey_q;
  assign res_value_o   = oval_q;
  assign res_present_o = opres_q;
  assign res_last_o    = olast_q;

endmodule

// File: rtl/sorted_groupby_aggregator.sv
`timescale 1ns / 1ps

// Group-by aggregation over a key column sorted ascending.
// Slave stream s_axis_*: one row per beat (key, value, value-present flag in
// tuser, last row of the table in tlast). Master stream m_axis_*: one beat per
// closed group (first key, aggregate, aggregate-present in tuser, final group
// of the table in tlast). cfg_*: register writes (index, data), always ready;
// write only while the block is idle.
// Path: a row that closes a group is written into the row queue, then the back
// end loads the group's beat into its output register, which drives
// m_axis_tvalid.
// Throughput: one row per cycle unless a stalled output beat holds the back
// end, set by its single add/compare per row. A final row whose key also closes
// the open group yields two beats and holds the back end until both are loaded.
// Reset: all groups are dropped, registers return to sum, unsigned keys and
// unsigned values, and m_axis_tvalid goes low.
// Stall: while m_axis_tready is low the output beat holds; rows that give no
// beat keep draining, and the 4-row queue absorbs the rest before
// s_axis_tready drops.
module sorted_groupby_aggregator #(
  parameter int unsigned KEY_WIDTH   = 64,
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // row stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sga_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // row_key, row_value
  input  logic [0:0]                      s_axis_tuser,  // value_present
  input  logic                            s_axis_tlast,  // final_row
  // group stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [sga_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // group_key, group_result
  output logic [0:0]                      m_axis_tuser,  // result_present
  output logic                            m_axis_tlast,  // last_group
  // register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sga_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sga_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned ENTRY_W = KEY_WIDTH + sga_pkg::FIELD_W + sga_pkg::FLAGS_W;

  sga_pkg::agg_op_e agg_op_q;
  logic             key_signed_q;
  logic             value_signed_q;
  logic             cfg_we;

  logic                        q_in_valid, q_in_ready;
  logic [ENTRY_W-1:0]          q_in_data;
  logic                        q_out_valid, q_pop;
  logic [ENTRY_W-1:0]          q_out_data;
  logic [KEY_WIDTH-1:0]        res_key;
  logic [sga_pkg::FIELD_W-1:0] res_key_ext;
  logic [sga_pkg::FIELD_W-1:0] res_value;
  logic                        res_present;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agg_op_q       <= sga_pkg::AGG_SUM;
      key_signed_q   <= 1'b0;
      value_signed_q <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        sga_pkg::CFG_AGG_OP:       agg_op_q       <= sga_pkg::agg_op_e'(cfg_data_i[1:0]);
        sga_pkg::CFG_KEY_SIGNED:   key_signed_q   <= cfg_data_i[0];
        sga_pkg::CFG_VALUE_SIGNED: value_signed_q <= cfg_data_i[0];
        default: ;  // unused index: ignored
      endcase
    end
  end

  // front: tracks the open group's key and classifies each row
  sga_front #(
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .key_signed_i    (key_signed_q),
    .value_signed_i  (value_signed_q),
    .row_valid_i     (s_axis_tvalid),
    .row_ready_o     (s_axis_tready),
    .row_key_i       (s_axis_tdata[sga_pkg::FIELD_W-1:0]),
    .row_value_i     (s_axis_tdata[sga_pkg::S_TDATA_W-1:sga_pkg::FIELD_W]),
    .value_present_i (s_axis_tuser[0]),
    .final_row_i     (s_axis_tlast),
    .push_valid_o    (q_in_valid),
    .push_ready_i    (q_in_ready),
    .push_data_o     (q_in_data)
  );

  sga_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_in_valid),
    .in_ready_o  (q_in_ready),
    .in_data_i   (q_in_data),
    .out_valid_o (q_out_valid),
    .out_ready_i (q_pop),
    .out_data_o  (q_out_data)
  );

  // back: accumulates and emits closed groups
  sga_back #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .agg_op_i       (agg_op_q),
    .value_signed_i (value_signed_q),
    .row_valid_i    (q_out_valid),
    .row_pop_o      (q_pop),
    .row_data_i     (q_out_data),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_key_o      (res_key),
    .res_value_o    (res_value),
    .res_present_o  (res_present),
    .res_last_o     (m_axis_tlast)
  );

  // zero-extend the key to the field width
  always_comb begin
    for (int i = 0; i < sga_pkg::FIELD_W; i++) begin
      res_key_ext[i] = (i < KEY_WIDTH) ? res_key[i] : 1'b0;
    end
  end

  assign m_axis_tdata = {res_value, res_key_ext};
  assign m_axis_tuser = res_present;

endmodule

// File: rtl/sga_checker.sv
`timescale 1ns / 1ps

module sga_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [sga_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic [0:0]                     m_axis_tuser,
  input logic                           m_axis_tlast
);

  // no group beat while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("group beat during reset");

  // an empty aggregate always reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0])
      |-> (m_axis_tdata[sga_pkg::M_TDATA_W-1:sga_pkg::FIELD_W] == '0))
    else $error("empty aggregate with nonzero result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("group beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready)
      |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast)))
    else $error("group beat changed while stalled");

endmodule

bind sorted_groupby_aggregator sga_checker u_sga_checker (.*);

// File: dv/sorted_groupby_aggregator_tb.sv
`timescale 1ns / 1ps

module sorted_groupby_aggregator_tb;

  localparam logic [sga_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register, write dropped
  localparam int unsigned DRAIN_CYCLES   = 8;     // row queue plus output register, with margin
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no beat on any channel
  localparam int unsigned RAND_PHASES    = 18;
  localparam int unsigned PHASE_ROWS     = 92;

  typedef logic [sga_pkg::FIELD_W-1:0] word_t;
  typedef logic [sga_pkg::CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [sga_pkg::CFG_DATA_W-1:0] cfg_data_t;

  typedef struct packed {
    word_t key;
    word_t value;
    logic  present;
    logic  fin;
  } row_t;

  typedef struct packed {
    word_t key;
    word_t agg;
    logic  present;
    logic  last;
  } grp_t;

  typedef enum logic {STEP_ROW, STEP_CFG} step_kind_e;

  typedef struct {
    step_kind_e kind;
    row_t       row;
    bit         typed;  // grp holds the hand-written result
    grp_t       grp;
    cfg_idx_t   idx;
    cfg_data_t  data;
  } dir_step_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [sga_pkg::S_TDATA_W-1:0]    s_axis_tdata;   // row_key, row_value
  logic [0:0]                       s_axis_tuser;   // value_present
  logic                             s_axis_tlast;   // final_row
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [sga_pkg::M_TDATA_W-1:0]    m_axis_tdata;   // group_key, group_result
  logic [0:0]                       m_axis_tuser;   // result_present
  logic                             m_axis_tlast;   // last_group
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  cfg_idx_t                         cfg_index_i;
  cfg_data_t                        cfg_data_i;

  sorted_groupby_aggregator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Aggregator model: register copy and open-group state, reset values
  sga_pkg::agg_op_e cfg_op = sga_pkg::AGG_SUM;
  bit      cfg_ks       = 1'b0;
  bit      cfg_vs       = 1'b0;
  bit      grp_open     = 1'b0;
  word_t   cur_key      = '0;
  word_t   acc          = '0;
  bit      acc_present  = 1'b0;

  grp_t    closed_now[$];      // groups closed by the row just folded
  grp_t    pending_groups[$];  // group beats still owed by the block
  dir_step_t steps[$];         // directed stimulus table
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit      src_idle_on = 1'b1;
  bit      snk_idle_on = 1'b1;

  function automatic void note_closed(grp_t g);
    closed_now.insert(closed_now.size(), g);
  endfunction

  function automatic void owe_group(grp_t g);
    pending_groups.insert(pending_groups.size(), g);
  endfunction

  function automatic void add_step(dir_step_t s);
    steps.insert(steps.size(), s);
  endfunction

  function automatic bit precedes(word_t a, word_t b, bit sgn);
    return sgn ? ($signed(a) < $signed(b)) : (a < b);
  endfunction

  function automatic grp_t close_rec(bit last);
    grp_t g;
    g.key     = cur_key;
    g.agg     = acc_present ? acc : '0;
    g.present = acc_present;
    g.last    = last;
    return g;
  endfunction

  function automatic void start_group(word_t k);
    grp_open    = 1'b1;
    cur_key     = k;
    acc         = '0;
    acc_present = 1'b0;
  endfunction

  // Fold one accepted row into the open group; closed groups land in closed_now
  function automatic void fold_row(row_t r);
    if (!grp_open) begin
      start_group(r.key);
    end else if (precedes(cur_key, r.key, cfg_ks)) begin
      // strictly greater key closes the old group first
      note_closed(close_rec(1'b0));
      start_group(r.key);
    end
    if (r.present) begin
      if (cfg_op == sga_pkg::AGG_COUNT) begin
        acc = acc + word_t'(1);
      end else if (!acc_present) begin
        acc = r.value;
      end else begin
        case (cfg_op)
          sga_pkg::AGG_SUM: acc = acc + r.value;
          sga_pkg::AGG_MIN: if (precedes(r.value, acc, cfg_vs)) acc = r.value;
          default:          if (precedes(acc, r.value, cfg_vs)) acc = r.value;
        endcase
      end
      acc_present = 1'b1;
    end
    if (r.fin) begin
      // last row of the table flushes whatever group holds this row
      note_closed(close_rec(1'b1));
      grp_open    = 1'b0;
      cur_key     = '0;
      acc         = '0;
      acc_present = 1'b0;
    end
  endfunction

  function automatic dir_step_t mk_row(word_t key, word_t value, bit p, bit f, bit typed,
                                       word_t gkey, word_t gagg, bit gp);
    dir_step_t s;
    s.kind        = STEP_ROW;
    s.row.key     = key;
    s.row.value   = value;
    s.row.present = p;
    s.row.fin     = f;
    s.typed       = typed;
    s.grp.key     = gkey;
    s.grp.agg     = gagg;
    s.grp.present = gp;
    s.grp.last    = 1'b1;  // typed results are all table flushes
    s.idx         = sga_pkg::CFG_AGG_OP;
    s.data        = '0;
    return s;
  endfunction

  function automatic dir_step_t mk_cfg(cfg_idx_t idx, cfg_data_t data);
    dir_step_t s;
    s.kind  = STEP_CFG;
    s.row   = '0;
    s.typed = 1'b0;
    s.grp   = '0;
    s.idx   = idx;
    s.data  = data;
    return s;
  endfunction

  // Key to open a table with: near the bottom, near the top, or anywhere
  function automatic word_t first_key();
    word_t k;
    case ($urandom_range(0, 2))
      0: k = cfg_ks ? {1'b1, 63'($urandom_range(0, 50))} : word_t'($urandom_range(0, 50));
      1: k = cfg_ks ? {1'b0, ~63'($urandom_range(0, 50000))} : ~word_t'($urandom_range(0, 50000));
      default: k = {$urandom, $urandom};
    endcase
    return k;
  endfunction

  function automatic int unsigned group_len();
    return ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 8);
  endfunction

  function automatic void check_field(string name, word_t want, word_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Drive one row beat; entered and left at a falling edge
  task automatic push_row(input row_t r, input bit typed, input grp_t tg);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.value, r.key};
    s_axis_tuser  <= r.present;
    s_axis_tlast  <= r.fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    closed_now.delete();
    fold_row(r);
    if (typed) begin
      owe_group(tg);
    end else begin
      foreach (closed_now[i]) owe_group(closed_now[i]);
    end
    @(negedge clk_i);
  endtask

  // Quiesce: stop rows, collect every owed beat, let silent rows drain out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_groups.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Leaves cfg_valid_i high; caller lowers it after the last write of a batch
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      sga_pkg::CFG_AGG_OP:       cfg_op = sga_pkg::agg_op_e'(data[1:0]);
      sga_pkg::CFG_KEY_SIGNED:   cfg_ks = data[0];
      sga_pkg::CFG_VALUE_SIGNED: cfg_vs = data[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // One random phase: register setting picked from the phase number, then
  // tables of sorted groups with some out-of-order keys and stray flushes
  task automatic run_phase(input int unsigned ph, input int unsigned n_rows,
                           input bit close_table);
    word_t       k;
    int unsigned grp_left;
    int unsigned tbl_groups;
    int unsigned i;
    row_t        r;
    grp_t        none;
    none = '0;
    settle();
    write_reg(sga_pkg::CFG_AGG_OP, {6'($urandom), ph[1:0]});
    write_reg(sga_pkg::CFG_KEY_SIGNED, {7'($urandom), ph[2]});
    write_reg(sga_pkg::CFG_VALUE_SIGNED, {7'($urandom), ph[3]});
    if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, 8'($urandom));
    cfg_valid_i <= 1'b0;
    k          = first_key();
    grp_left   = group_len();
    tbl_groups = $urandom_range(1, 12);
    for (i = 0; i < n_rows; i++) begin
      case ($urandom_range(0, 24))
        0: r.key = k - word_t'($urandom_range(1, 1000));  // smaller key joins the group
        1: r.key = {$urandom, $urandom};                  // stray key
        default: r.key = k;
      endcase
      case ($urandom_range(0, 5))
        0, 1: r.value = {$urandom, $urandom};
        2: r.value = word_t'($urandom_range(0, 15));
        3: r.value = ~word_t'($urandom_range(0, 15));
        4: r.value = $urandom_range(0, 1) ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        default: r.value = $urandom_range(0, 1) ? '1 : '0;
      endcase
      r.present = ($urandom_range(0, 4) != 0);
      r.fin     = ($urandom_range(0, 60) == 0);  // flush in the middle of a group
      grp_left--;
      if (grp_left == 0) begin
        tbl_groups--;
        if (tbl_groups == 0) begin
          // a one-row last group gives boundary and flush on the same row
          r.fin      = 1'b1;
          tbl_groups = $urandom_range(1, 12);
          k          = first_key();
        end else begin
          k = k + word_t'(1) + ({$urandom, $urandom} >> $urandom_range(20, 63));
        end
        grp_left = group_len();
      end
      if (close_table && i == n_rows - 1) r.fin = 1'b1;
      push_row(r, 1'b0, none);
    end
  endtask

  // Sink: ready drops in random bursts while idling is on
  initial begin : group_sink
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (snk_idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Every group beat is checked against the oldest owed result
  always @(posedge clk_i) begin : group_monitor
    grp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_groups.size() == 0) begin
        $display("%0t: group beat with none expected, key %h result %h", $time,
                 m_axis_tdata[sga_pkg::FIELD_W-1:0],
                 m_axis_tdata[2*sga_pkg::FIELD_W-1:sga_pkg::FIELD_W]);
        mismatches++;
      end else begin
        want = pending_groups.pop_front();
        check_field("group_key", want.key, m_axis_tdata[sga_pkg::FIELD_W-1:0]);
        check_field("group_result", want.agg,
                    m_axis_tdata[2*sga_pkg::FIELD_W-1:sga_pkg::FIELD_W]);
        check_field("result_present", word_t'(want.present), word_t'(m_axis_tuser));
        check_field("last_group", word_t'(want.last), word_t'(m_axis_tlast));
      end
    end
  end

  // Watchdog: too long with no beat anywhere means the block hung
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned ph;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = sga_pkg::CFG_AGG_OP;
    cfg_data_i    = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows. Reset setting: sum, unsigned keys, unsigned values.
    // single-row table right after reset
    add_step(mk_row(64'd5, 64'd10, 1'b1, 1'b1, 1'b1, 64'd5, 64'd10, 1'b1));
    // sum wraps past all ones
    add_step(mk_row(64'd0, '1, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0));
    add_step(mk_row(64'd0, 64'd1, 1'b1, 1'b1, 1'b1, 64'd0, 64'd0, 1'b1));
    // group with no valid value
    add_step(mk_row(64'd7, 64'h1234, 1'b0, 1'b1, 1'b1, 64'd7, 64'd0, 1'b0));
    // smaller key stays in the group, then boundary and flush on one row
    add_step(mk_row(64'd1, 64'd3, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0));
    add_step(mk_row(64'd1, 64'd4, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0));
    add_step(mk_row(64'd0, 64'd5, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0));
    add_step(mk_row(64'd2, 64'd6, 1'b1, 1'b1, 1'b0, '0, '0, 1'b0));
    // top key
    add_step(mk_row('1, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1, 1'b1, 1'b1,
                    '1, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1));
    add_step(mk_cfg(sga_pkg::CFG_AGG_OP, 8'hFD));  // count, upper data bits set
    add_step(mk_row(64'd3, 64'd9, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0));
    add_step(mk_row(64'd3, 64'd9, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0));
    add_step(mk_row(64'd3, 64'd9, 1'b1, 1'b1, 1'b1, 64'd3, 64'd2, 1'b1));
    add_step(mk_row(64'd4, 64'd9, 1'b0, 1'b1, 1'b1, 64'd4, 64'd0, 1'b0));
    add_step(mk_cfg(sga_pkg::CFG_AGG_OP, 8'h02));        // min
    add_step(mk_cfg(sga_pkg::CFG_VALUE_SIGNED, 8'hFF));  // signed values
    add_step(mk_row(64'd10, {1'b1, 63'd0}, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0));
    add_step(mk_row(64'd10, 64'd5, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0));
    add_step(mk_row(64'd11, {1'b0, {63{1'b1}}}, 1'b1, 1'b1, 1'b0, '0, '0, 1'b0));
    add_step(mk_cfg(sga_pkg::CFG_AGG_OP, 8'h03));      // max
    add_step(mk_cfg(sga_pkg::CFG_KEY_SIGNED, 8'h01));  // signed keys: -1 before 0
    add_step(mk_row('1, ~64'd4, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0));
    add_step(mk_row(64'd0, '1, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0));
    add_step(mk_row({1'b0, {63{1'b1}}}, {1'b1, 63'd0}, 1'b1, 1'b1, 1'b0, '0, '0, 1'b0));
    add_step(mk_cfg(sga_pkg::CFG_KEY_SIGNED, 8'h00));
    add_step(mk_cfg(sga_pkg::CFG_VALUE_SIGNED, 8'hFE));
    add_step(mk_cfg(sga_pkg::CFG_AGG_OP, 8'h00));

    foreach (steps[i]) begin
      if (steps[i].kind == STEP_CFG) begin
        settle();
        write_reg(steps[i].idx, steps[i].data);
        cfg_valid_i <= 1'b0;
      end else begin
        push_row(steps[i].row, steps[i].typed, steps[i].grp);
      end
    end

    // Random phases; the last two run with no idling on either side
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      src_idle_on = (ph < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
      snk_idle_on = (ph < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
      run_phase(ph, PHASE_ROWS, (ph == RAND_PHASES - 1) || ($urandom_range(0, 1) == 1));
    end

    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sga_pkg.sv
rtl/sga_queue.sv
rtl/sga_front.sv
rtl/sga_back.sv
rtl/sorted_groupby_aggregator.sv
rtl/sga_checker.sv
dv/sorted_groupby_aggregator_tb.sv
